>>> src/indexed_insert_remove_array_unit_defines.svh
// Assertion macros used by the top level of the indexed insert/remove array RTL.
`ifndef INDEXED_INSERT_REMOVE_ARRAY_UNIT_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_ARRAY_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IIRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("iira check failed");

// Consequent must hold in the cycle after the antecedent.
`define IIRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("iira check failed");

`endif

>>> src/iira_pkg.sv
// Types and codes for the indexed insert/remove array.
package iira_pkg;

	// widest cell index for the largest supported depth
	localparam int IDX_W = 8;

	typedef enum logic [2:0] {
		MODE_APPEND   = 3'd0,
		MODE_INSERT   = 3'd1,
		MODE_REMOVE   = 3'd2,
		MODE_TRUNCATE = 3'd3,
		MODE_CLEAR    = 3'd4,
		MODE_READ     = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_BAD  = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		SHIFT_HOLD   = 2'd0,
		SHIFT_INSERT = 2'd1,
		SHIFT_REMOVE = 2'd2
	} shift_op_t;

	// broadcast to every cell of the row
	typedef struct packed {
		shift_op_t        op;
		logic [IDX_W-1:0] idx;
	} shift_cmd_t;

endpackage

>>> src/iira_cell.sv
// One storage cell of the array row: hold, load, or take a neighbor's word.
module iira_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int IDX        = 0
) (
	input  logic                    clk,
	input  iira_pkg::shift_cmd_t    cmd,
	input  logic [DATA_WIDTH-1:0]   new_data,
	input  logic [DATA_WIDTH-1:0]   lower_data,  // from cell IDX-1
	input  logic [DATA_WIDTH-1:0]   upper_data,  // from cell IDX+1
	output logic [DATA_WIDTH-1:0]   data
);
	import iira_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_d;

	always_comb begin
		data_d = data_q;
		unique case (cmd.op)
			SHIFT_INSERT: begin
				if (MY_IDX == cmd.idx) begin
					data_d = new_data;
				end else if (MY_IDX > cmd.idx) begin
					data_d = lower_data;
				end
			end
			SHIFT_REMOVE: begin
				if (MY_IDX >= cmd.idx) begin
					data_d = upper_data;
				end
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

>>> src/indexed_insert_remove_array_unit.sv
// Top level of the indexed insert/remove array: command decode, cell row, result register.
// A command's result is registered and shown in the cycle after its transfer.
// Throughput: one command per cycle; every cell shifts, loads or holds in parallel.
// The input stalls only while a finished result waits on the output side.
// Reset clears the entry count and the result valid; cell contents are left undefined.
module indexed_insert_remove_array_unit #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // position[4:0], entry_value[36:5], zero[39:37]
	input  logic [2:0]  s_axis_tuser,  // mode[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // read_value[31:0], status[33:32],
	                                   // entry_count[38:34], is_empty[39]
);
	import iira_pkg::*;

`include "indexed_insert_remove_array_unit_defines.svh"

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
	localparam int SEL_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic                  out_valid_q;
	logic [31:0]           read_value_q;
	status_t               status_q;

	logic                  accept;
	mode_t                 mode;
	logic [CMP_W-1:0]      pos_w;
	logic [CMP_W-1:0]      cnt_w;
	logic                  full;
	status_t               status_d;
	logic [31:0]           read_value_d;
	shift_op_t             op_d;
	logic [IDX_W-1:0]      idx_d;
	shift_cmd_t            cmd;
	logic [DATA_WIDTH-1:0] new_data;
	logic [DATA_WIDTH-1:0] cell_data [DEPTH];

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign mode          = mode_t'(s_axis_tuser);
	assign pos_w         = CMP_W'(s_axis_tdata[4:0]);
	assign cnt_w         = CMP_W'(count_q);
	assign full          = (cnt_w >= CMP_W'(DEPTH));
	assign new_data      = DATA_WIDTH'(s_axis_tdata[36:5]);

	always_comb begin
		status_d     = STATUS_OK;
		count_d      = count_q;
		read_value_d = '0;
		op_d         = SHIFT_HOLD;
		idx_d        = IDX_W'(pos_w);
		unique case (mode)
			MODE_APPEND: begin
				if (full) begin
					status_d = STATUS_FULL;
				end else begin
					op_d    = SHIFT_INSERT;
					idx_d   = IDX_W'(cnt_w);
					count_d = CNT_W'(count_q + 1'b1);
				end
			end
			MODE_INSERT: begin
				if (pos_w > cnt_w) begin
					status_d = STATUS_BAD;
				end else if (full) begin
					status_d = STATUS_FULL;
				end else begin
					op_d    = SHIFT_INSERT;
					count_d = CNT_W'(count_q + 1'b1);
				end
			end
			MODE_REMOVE: begin
				if (pos_w >= cnt_w) begin
					status_d = STATUS_BAD;
				end else begin
					op_d    = SHIFT_REMOVE;
					count_d = CNT_W'(count_q - 1'b1);
				end
			end
			MODE_TRUNCATE: begin
				if (pos_w > cnt_w) begin
					status_d = STATUS_BAD;
				end else begin
					count_d = CNT_W'(pos_w);
				end
			end
			MODE_CLEAR: begin
				count_d = '0;
			end
			MODE_READ: begin
				if (pos_w >= cnt_w) begin
					status_d = STATUS_BAD;
				end else begin
					read_value_d = 32'(cell_data[pos_w[SEL_W-1:0]]);
				end
			end
			default: status_d = STATUS_BAD;
		endcase
	end

	// cells only move on a transfer
	assign cmd.op  = accept ? op_d : SHIFT_HOLD;
	assign cmd.idx = idx_d;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] lower;
		logic [DATA_WIDTH-1:0] upper;
		if (i == 0) begin : g_first
			assign lower = new_data;
		end else begin : g_mid_lo
			assign lower = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign upper = cell_data[i];
		end else begin : g_mid_hi
			assign upper = cell_data[i+1];
		end
		iira_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.IDX        (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.new_data   (new_data),
			.lower_data (lower),
			.upper_data (upper),
			.data       (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_value_q <= read_value_d;
			status_q     <= status_d;
		end
	end

	// entry count is live state; it only changes together with the result register
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(count_q == '0), 5'(count_q), status_q, read_value_q};

	`IIRA_ASSERT_NOW(a_count_in_range, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH))
	`IIRA_ASSERT_NEXT(a_error_keeps_count, clk, arst_n,
		accept && status_d != STATUS_OK, $stable(count_q))
	`IIRA_ASSERT_NEXT(a_append_grows, clk, arst_n,
		accept && mode == MODE_APPEND && status_d == STATUS_OK,
		count_q == CNT_W'($past(count_q) + 1'b1))
	`IIRA_ASSERT_NEXT(a_clear_empties, clk, arst_n,
		accept && mode == MODE_CLEAR, count_q == '0)
	`IIRA_ASSERT_NOW(a_error_reads_zero, clk, arst_n,
		out_valid_q && status_q != STATUS_OK, read_value_q == '0)

endmodule
